[design/mlfd_pkg.sv]
// Shared types, codes and the glyph font table of the framebuffer draw block.
`timescale 1ns / 1ps

package mlfd_pkg;

  typedef enum logic [2:0] {
    ACT_SET   = 3'd0,
    ACT_CLR   = 3'd1,
    ACT_HRUN  = 3'd2,
    ACT_VRUN  = 3'd3,
    ACT_GLYPH = 3'd4,
    ACT_ERASE = 3'd5,
    ACT_READ  = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    ST_BOOT,
    ST_IDLE,
    ST_STEP,
    ST_WR,
    ST_ERASE,
    ST_FIN
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic clr_write;
    logic advance;
    logic do_wr;
    logic result_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic step_active;
    logic step_last;
    logic clr_last;
  } dp_stat_t;

  localparam int unsigned RomColumns = 6;
  localparam int unsigned RomFirst   = 32;

  // One row per printable code, first column in the top byte
  localparam logic [47:0] GLYPH_ROM [96] = '{
    48'h000000000000, 48'h00065F060000, 48'h070300070300, 48'h247E247E2400,
    48'h242B6A120000, 48'h631308646300, 48'h304C52225000, 48'h000703000000,
    48'h003E41000000, 48'h00413E000000, 48'h083E1C3E0800, 48'h08083E080800,
    48'h806060000000, 48'h080808080800, 48'h006060000000, 48'h201008040200,
    48'h3E5149453E00, 48'h00427F400000, 48'h625149494600, 48'h224949493600,
    48'h1814127F1000, 48'h2F4949493100, 48'h3C4A49493000, 48'h017109050300,
    48'h364949493600, 48'h064949291E00, 48'h006C6C000000, 48'h00EC6C000000,
    48'h081422410000, 48'h242424242400, 48'h004122140800, 48'h020159090600,
    48'h3E415D551E00, 48'h7E1111117E00, 48'h7F4949493600, 48'h3E4141412200,
    48'h7F4141413E00, 48'h7F4949494100, 48'h7F0909090100, 48'h3E4149497A00,
    48'h7F0808087F00, 48'h00417F410000, 48'h304040403F00, 48'h7F0814224100,
    48'h7F4040404000, 48'h7F0204027F00, 48'h7F0204087F00, 48'h3E4141413E00,
    48'h7F0909090600, 48'h3E4151215E00, 48'h7F0909196600, 48'h264949493200,
    48'h01017F010100, 48'h3F4040403F00, 48'h1F2040201F00, 48'h3F403C403F00,
    48'h631408146300, 48'h070870080700, 48'h714945430000, 48'h007F41410000,
    48'h020408102000, 48'h0041417F0000, 48'h040201020400, 48'h808080808000,
    48'h000205020000, 48'h205454547800, 48'h7F4444443800, 48'h384444442800,
    48'h384444447F00, 48'h385454540800, 48'h087E09090000, 48'h1824A4A4FC00,
    48'h7F0404780000, 48'h00007D400000, 48'h4080847D0000, 48'h7F1028440000,
    48'h00007F400000, 48'h7C0418047800, 48'h7C0404780000, 48'h384444443800,
    48'hFC4444443800, 48'h38444444FC00, 48'h447844040800, 48'h085454542000,
    48'h043E44240000, 48'h3C40207C0000, 48'h1C2040201C00, 48'h3C6030603C00,
    48'h6C10106C0000, 48'h9CA0603C0000, 48'h6454544C0000, 48'h083E41410000,
    48'h000077000000, 48'h0041413E0800, 48'h020102010000, 48'h102040380700
  };

  // Control codes below the printable range have blank glyphs
  function automatic logic [47:0] glyph_row(input logic [6:0] code);
    logic [6:0] idx;
    idx = code - 7'(RomFirst);
    if (code < 7'(RomFirst)) begin
      return 48'h0;
    end
    return GLYPH_ROM[idx];
  endfunction

endpackage

[design/mlfd_ctrl.sv]
// Command sequencer of the framebuffer draw block.
`timescale 1ns / 1ps

module mlfd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [2:0]          action_i,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output mlfd_pkg::ctrl_cmd_t cmd_o,
  input  mlfd_pkg::dp_stat_t  stat_i
);

  mlfd_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mlfd_pkg::ST_BOOT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      mlfd_pkg::ST_BOOT: begin
        cmd_o.clr_write = 1'b1;
        if (stat_i.clr_last) begin
          state_d = mlfd_pkg::ST_IDLE;
        end
      end
      mlfd_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.accept = 1'b1;
          case (mlfd_pkg::action_e'(action_i))
            mlfd_pkg::ACT_SET, mlfd_pkg::ACT_CLR, mlfd_pkg::ACT_HRUN,
            mlfd_pkg::ACT_VRUN, mlfd_pkg::ACT_GLYPH, mlfd_pkg::ACT_READ: begin
              state_d = mlfd_pkg::ST_STEP;
            end
            mlfd_pkg::ACT_ERASE: begin
              state_d = mlfd_pkg::ST_ERASE;
            end
            default: begin
              state_d = mlfd_pkg::ST_FIN;
            end
          endcase
        end
      end
      mlfd_pkg::ST_STEP: begin
        if (stat_i.step_active) begin
          state_d = mlfd_pkg::ST_WR;
        end else begin
          cmd_o.advance = 1'b1;
          if (stat_i.step_last) begin
            state_d = mlfd_pkg::ST_FIN;
          end
        end
      end
      mlfd_pkg::ST_WR: begin
        cmd_o.do_wr   = 1'b1;
        cmd_o.advance = 1'b1;
        state_d = stat_i.step_last ? mlfd_pkg::ST_FIN : mlfd_pkg::ST_STEP;
      end
      mlfd_pkg::ST_ERASE: begin
        cmd_o.clr_write = 1'b1;
        if (stat_i.clr_last) begin
          state_d = mlfd_pkg::ST_FIN;
        end
      end
      mlfd_pkg::ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          cmd_o.result_load = 1'b1;
          state_d = mlfd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mlfd_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d   = (out_valid_q && !m_axis_tready) || cmd_o.result_load;
  assign m_axis_tvalid = out_valid_q;

endmodule

[design/mlfd_datapath.sv]
// Command registers, step addressing, pixel masks and frame memory.
`timescale 1ns / 1ps

module mlfd_datapath #(
  parameter int unsigned PANEL_WIDTH   = 100,
  parameter int unsigned PANEL_HEIGHT  = 64,
  parameter int unsigned GLYPH_COLUMNS = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mlfd_pkg::ctrl_cmd_t cmd_i,
  output mlfd_pkg::dp_stat_t  stat_o,
  input  logic [2:0]          action_i,
  input  logic [6:0]          pos_x_i,
  input  logic [6:0]          pos_y_i,
  input  logic [6:0]          run_end_i,
  input  logic [6:0]          glyph_code_i,
  output logic [7:0]          read_byte_o,
  output logic                clipped_o
);

  localparam int unsigned Pages = (PANEL_HEIGHT + 7) / 8;
  localparam int unsigned Depth = Pages * PANEL_WIDTH;
  localparam int unsigned AW    = $clog2(Depth);
  localparam logic [7:0]  WidthC  = 8'(PANEL_WIDTH);
  localparam logic [7:0]  HeightC = 8'(PANEL_HEIGHT);
  localparam logic [4:0]  PagesC  = 5'(Pages);

  logic [7:0]  mem_q [Depth];
  logic [7:0]  rdata_q;

  mlfd_pkg::action_e act_q;
  logic [6:0]  px_q, py_q, pend_q, cur_q;
  logic [47:0] row_q;
  logic        hi_q, clip_q;
  logic [7:0]  rbyte_q, out_byte_q;
  logic        out_clip_q;
  logic [AW-1:0] clr_cnt_q;

  logic        init_clip;
  logic [7:0]  cur8, nxt8, lim;
  logic        st_active, st_last, st_clear;
  logic [7:0]  st_x, st_mask;
  logic [4:0]  st_page;
  logic [AW-1:0] st_addr;
  logic [2:0]  gc;
  logic [7:0]  gcol, gvmask, gx;
  logic [15:0] gshift;
  logic        col_clip;

  // Clip flag known at accept for everything but glyphs
  always_comb begin
    case (mlfd_pkg::action_e'(action_i))
      mlfd_pkg::ACT_SET, mlfd_pkg::ACT_CLR: begin
        init_clip = ({1'b0, pos_x_i} >= WidthC) || ({1'b0, pos_y_i} >= HeightC);
      end
      mlfd_pkg::ACT_HRUN: begin
        init_clip = (run_end_i > pos_x_i) &&
                    (({1'b0, pos_y_i} >= HeightC) || ({1'b0, run_end_i} > WidthC));
      end
      mlfd_pkg::ACT_VRUN: begin
        init_clip = (run_end_i > pos_y_i) &&
                    (({1'b0, pos_x_i} >= WidthC) || ({1'b0, run_end_i} > HeightC));
      end
      mlfd_pkg::ACT_READ: begin
        init_clip = ({1'b0, pos_x_i} >= WidthC) || ({1'b0, pos_y_i[6:3]} >= PagesC);
      end
      default: begin
        init_clip = 1'b0;
      end
    endcase
  end

  // Glyph column under the cursor, split across two pages
  always_comb begin
    gc   = cur_q[2:0];
    gcol = 8'h00;
    for (int k = 0; k < mlfd_pkg::RomColumns; k++) begin
      if (gc == 3'(k)) begin
        gcol = row_q[(mlfd_pkg::RomColumns - 1 - k) * 8 +: 8];
      end
    end
    for (int b = 0; b < 8; b++) begin
      gvmask[b] = (({1'b0, py_q} + 8'(b)) < HeightC);
    end
    gx       = {1'b0, px_q} + {5'b0, gc};
    gshift   = {8'h00, gcol & gvmask} << py_q[2:0];
    col_clip = (|(gcol & ~gvmask)) || ((gx >= WidthC) && (|gcol));
  end

  always_comb begin
    cur8      = {1'b0, cur_q};
    nxt8      = cur8 + 8'd1;
    lim       = 8'h00;
    st_active = 1'b0;
    st_last   = 1'b1;
    st_clear  = 1'b0;
    st_x      = {1'b0, px_q};
    st_page   = {1'b0, py_q[6:3]};
    st_mask   = 8'h01 << py_q[2:0];
    case (act_q)
      mlfd_pkg::ACT_SET, mlfd_pkg::ACT_CLR: begin
        st_active = ({1'b0, px_q} < WidthC) && ({1'b0, py_q} < HeightC);
        st_clear  = (act_q == mlfd_pkg::ACT_CLR);
      end
      mlfd_pkg::ACT_HRUN: begin
        lim       = ({1'b0, pend_q} < WidthC) ? {1'b0, pend_q} : WidthC;
        st_active = (cur8 < lim) && ({1'b0, py_q} < HeightC);
        st_last   = (nxt8 >= lim);
        st_x      = cur8;
      end
      mlfd_pkg::ACT_VRUN: begin
        lim       = ({1'b0, pend_q} < HeightC) ? {1'b0, pend_q} : HeightC;
        st_active = (cur8 < lim) && ({1'b0, px_q} < WidthC);
        st_last   = (nxt8 >= lim);
        st_page   = {1'b0, cur_q[6:3]};
        st_mask   = 8'h01 << cur_q[2:0];
      end
      mlfd_pkg::ACT_GLYPH: begin
        st_x      = gx;
        st_page   = {1'b0, py_q[6:3]} + {4'b0, hi_q};
        st_mask   = hi_q ? gshift[15:8] : gshift[7:0];
        st_active = (gx < WidthC) && (|st_mask);
        st_last   = hi_q && (gc == 3'(GLYPH_COLUMNS - 1));
      end
      mlfd_pkg::ACT_READ: begin
        st_active = ({1'b0, px_q} < WidthC) && ({1'b0, py_q[6:3]} < PagesC);
      end
      default: begin
        st_active = 1'b0;
      end
    endcase
    st_addr = AW'(16'(st_page) * 16'(PANEL_WIDTH) + 16'(st_x));
  end

  assign stat_o.step_active = st_active;
  assign stat_o.step_last   = st_last;
  assign stat_o.clr_last    = (clr_cnt_q == AW'(Depth - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_write) begin
      clr_cnt_q <= stat_o.clr_last ? '0 : clr_cnt_q + AW'(1);
    end
  end

  // Frame memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_write) begin
      mem_q[clr_cnt_q] <= 8'h00;
    end else if (cmd_i.do_wr && act_q != mlfd_pkg::ACT_READ) begin
      mem_q[st_addr] <= st_clear ? (rdata_q & ~st_mask) : (rdata_q | st_mask);
    end
    rdata_q <= mem_q[st_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q   <= mlfd_pkg::action_e'(action_i);
      px_q    <= pos_x_i;
      py_q    <= pos_y_i;
      pend_q  <= run_end_i;
      row_q   <= mlfd_pkg::glyph_row(glyph_code_i);
      hi_q    <= 1'b0;
      clip_q  <= init_clip;
      rbyte_q <= 8'h00;
      case (mlfd_pkg::action_e'(action_i))
        mlfd_pkg::ACT_HRUN: cur_q <= pos_x_i;
        mlfd_pkg::ACT_VRUN: cur_q <= pos_y_i;
        default:            cur_q <= 7'd0;
      endcase
    end else begin
      if (cmd_i.do_wr && act_q == mlfd_pkg::ACT_READ) begin
        rbyte_q <= rdata_q;
      end
      if (cmd_i.advance) begin
        if (act_q == mlfd_pkg::ACT_GLYPH) begin
          hi_q   <= ~hi_q;
          clip_q <= clip_q | col_clip;
          if (hi_q) begin
            cur_q <= cur_q + 7'd1;
          end
        end else begin
          cur_q <= cur_q + 7'd1;
        end
      end
    end
    if (cmd_i.result_load) begin
      out_byte_q <= rbyte_q;
      out_clip_q <= clip_q;
    end
  end

  assign read_byte_o = out_byte_q;
  assign clipped_o   = out_clip_q;

endmodule

[design/mono_lcd_framebuffer_draw.sv]
// Top level of the page-organised monochrome framebuffer with drawing commands.
`timescale 1ns / 1ps

// Usage:
//   Commands arrive on the s_axis channel, one word per command; the action code
//   travels on tuser, the coordinates and glyph code on tdata. Every command
//   returns exactly one word on m_axis: the read byte (zero unless a read) and
//   the clipped flag. Pixels live in pages of column bytes, bit y%8 of byte
//   (y/8)*PANEL_WIDTH+x.
//   Each pixel change is a read-modify-write of one memory byte through the
//   frame memory's registered read port and its write port; a skipped step
//   writes nothing. Set, clear and read take one step; a glyph takes two steps
//   per column, one per page; a run takes one step per pixel; erase sweeps the
//   whole store one byte a cycle.
//   After reset the store is swept to zero in the same way; tready stays low
//   until the sweep ends.
//   The result sits in an output register; a new command is taken while it
//   waits, and the block holds a finished result back only when the output
//   register is still full because the receiver stalls.
module mono_lcd_framebuffer_draw #(
  parameter int unsigned PANEL_WIDTH   = 100,
  parameter int unsigned PANEL_HEIGHT  = 64,
  parameter int unsigned GLYPH_COLUMNS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // pos_x[6:0], pos_y[13:7], run_end[20:14],
                                     // glyph_code[27:21], zero[31:28]
  input  logic [2:0]  s_axis_tuser,  // action[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // read_byte[7:0], clipped[8], zero[15:9]
);

  mlfd_pkg::ctrl_cmd_t cmd;
  mlfd_pkg::dp_stat_t  stat;
  logic [7:0]          read_byte;
  logic                clipped;

  // Sequencer: boot sweep, command steps, result hand-off
  mlfd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .action_i      (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd),
    .stat_i        (stat)
  );

  // Addressing, masks, frame memory and result registers
  mlfd_datapath #(
    .PANEL_WIDTH   (PANEL_WIDTH),
    .PANEL_HEIGHT  (PANEL_HEIGHT),
    .GLYPH_COLUMNS (GLYPH_COLUMNS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .action_i     (s_axis_tuser),
    .pos_x_i      (s_axis_tdata[6:0]),
    .pos_y_i      (s_axis_tdata[13:7]),
    .run_end_i    (s_axis_tdata[20:14]),
    .glyph_code_i (s_axis_tdata[27:21]),
    .read_byte_o  (read_byte),
    .clipped_o    (clipped)
  );

  // Pack the result word
  assign m_axis_tdata = {7'b0, clipped, read_byte};

endmodule
